// ===== rtl/core/ole_pkg.sv =====
// Shared types and codes for the ordered list engine.
`default_nettype none

package ole_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      REQ_APPEND = 3'd0,
      REQ_POP    = 3'd1,
      REQ_INSERT = 3'd2,
      REQ_DELETE = 3'd3,
      REQ_SEARCH = 3'd4,
      REQ_CLEAR  = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_SEARCH,
      CELL_POP
   } cell_cmd_type;

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_cmd_type      cmd;
      logic              mark;   // capture a fresh flag this cycle
      logic [DATA_W-1:0] key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/ordered_list_engine.sv =====
// Ordered list engine: an ordered list of signed words kept in a chain of cells.
//
// Requests arrive on req_* (valid/stall); an item is taken when req_valid is
// high and req_stall is low. Codes: append, pop tail, insert before position,
// delete at position, search for first match, clear. Each item returns one
// result on rsp_* with a status, the popped value, the search hit and the
// entry count after the request.
// Sequence: the accept edge updates the cell chain and captures per-cell
// flags; in the reduce state (S_EVAL) the flags are reduced (first-match
// encode, popped-value select) and the result is loaded into the output
// register once that register is free. No new item is taken until the
// result of the previous one has been loaded.
// req_stall is high during the reduce cycle, and stays high while a result
// is ready but the output register still holds an untaken result under
// rsp_stall. A new item may be taken while an earlier result waits.
// Reset (synchronous, active high) empties the list and drops any pending
// result; entry storage itself is not cleared.
`default_nettype none

module ordered_list_engine import ole_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_type,
   input  wire logic [4:0]         req_position,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_popped_value,
   output logic                    rsp_found,
   output logic [3:0]              rsp_found_position,
   output logic [4:0]              rsp_entry_count
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 5) ? CW : 5;
   localparam int XW = (IW > 4) ? IW : 4;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   req_code_type  op_ff, op_in;
   status_type    status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_popped_ff, rsp_popped_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [3:0]        rsp_pos_ff, rsp_pos_in;
   logic [4:0]        rsp_count_ff, rsp_count_in;

   cell_ctrl_type     ctrl;
   logic [IW-1:0]     at_idx;
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]  cell_flag;

   logic          accept;
   logic          load_rsp;
   logic [PW-1:0] pos_x;
   logic [PW-1:0] cnt_x;
   logic [PW-1:0] cnt_wide;
   logic [XW-1:0] hit_idx;
   logic [31:0]   pop_sel;

   assign req_stall = (state_ff == S_EVAL);
   assign accept    = req_valid && !req_stall;
   assign pos_x     = PW'(req_position);
   assign cnt_x     = PW'(count_ff);

   // request decode, done at the accept edge
   always_comb begin
      count_in  = count_ff;
      op_in     = op_ff;
      status_in = status_ff;
      ctrl.cmd  = CELL_HOLD;
      ctrl.mark = accept;
      ctrl.key  = req_value;
      at_idx    = '0;
      if (accept) begin
         op_in     = req_code_type'(req_type);
         status_in = ST_OK;
         case (req_code_type'(req_type))
            REQ_APPEND: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.cmd = CELL_INSERT;
                  at_idx   = count_ff[IW-1:0];
                  count_in = count_ff + CW'(1);
               end
            end
            REQ_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_RANGE;
               end else begin
                  ctrl.cmd = CELL_POP;
                  at_idx   = IW'(count_ff - CW'(1));
                  count_in = count_ff - CW'(1);
               end
            end
            REQ_INSERT: begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else if (pos_x > cnt_x) begin
                  status_in = ST_RANGE;
               end else begin
                  ctrl.cmd = CELL_INSERT;
                  at_idx   = IW'(pos_x);
                  count_in = count_ff + CW'(1);
               end
            end
            REQ_DELETE: begin
               if (pos_x >= cnt_x) begin
                  status_in = ST_RANGE;
               end else begin
                  ctrl.cmd = CELL_DELETE;
                  at_idx   = IW'(pos_x);
                  count_in = count_ff - CW'(1);
               end
            end
            REQ_SEARCH: begin
               ctrl.cmd = CELL_SEARCH;
            end
            REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // cell chain; insert shifts toward the tail, delete toward the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      if (i == 0) begin : g_head
         assign left_d = ctrl.key;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      ole_cell #(
         .INDEX (i),
         .IW    (IW),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .at_idx     (at_idx),
         .count      (count_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i]),
         .flag_out   (cell_flag[i])
      );
   end

   // flag reduction: first match and popped word
   always_comb begin
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_flag[i]) begin
            hit_idx = XW'(i);
         end
      end
      pop_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pop_sel = pop_sel | (cell_data[i] & {32{cell_flag[i]}});
      end
   end

   assign cnt_wide = PW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      load_rsp      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp      = 1'b1;
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_popped_in = (op_ff == REQ_POP) ? pop_sel : '0;
               rsp_found_in  = (op_ff == REQ_SEARCH) && (|cell_flag);
               rsp_pos_in    = ((op_ff == REQ_SEARCH) && (|cell_flag)) ?
                               hit_idx[3:0] : 4'd0;
               rsp_count_in  = cnt_wide[4:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_popped_value   = rsp_popped_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_entry_count    = rsp_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above depth");

   a_accept_eval : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EVAL)
      else $error("accepted item did not enter reduce cycle");

   a_pop_onehot : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) && (op_ff == REQ_POP) |-> $onehot0(cell_flag))
      else $error("more than one cell selected for pop");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) && (status_ff == ST_FULL) |-> count_ff == FULL_COUNT)
      else $error("full status with list not full");

   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) && rsp_valid_ff && rsp_stall |=> state_ff == S_EVAL)
      else $error("pending result overwritten");

   a_load_state : assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("result load lost");

endmodule

`default_nettype wire

// ===== rtl/core/ole_cell.sv =====
// One storage cell of the list chain: holds an entry and a flag bit.
`default_nettype none

module ole_cell import ole_pkg::*; #(
   parameter int INDEX = 0,
   parameter int IW    = 4,
   parameter int CW    = 5
) (
   input  wire logic              clock,
   input  wire cell_ctrl_type     ctrl,
   input  wire logic [IW-1:0]     at_idx,
   input  wire logic [CW-1:0]     count,
   input  wire logic [DATA_W-1:0] left_data,
   input  wire logic [DATA_W-1:0] right_data,
   output logic      [DATA_W-1:0] data_out,
   output logic                   flag_out
);

   localparam logic [IW-1:0] IDX   = IW'(INDEX);
   localparam logic [CW-1:0] IDX_C = CW'(INDEX);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              flag_ff, flag_in;

   always_comb begin
      data_in = data_ff;
      flag_in = 1'b0;
      case (ctrl.cmd)
         CELL_INSERT: begin
            if (IDX > at_idx) begin
               data_in = left_data;
            end else if (IDX == at_idx) begin
               data_in = ctrl.key;
            end
         end
         CELL_DELETE: begin
            if (IDX >= at_idx) begin
               data_in = right_data;
            end
         end
         CELL_SEARCH: begin
            flag_in = (IDX_C < count) && (data_ff == ctrl.key);
         end
         CELL_POP: begin
            flag_in = (IDX == at_idx);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctrl.mark) begin
         flag_ff <= flag_in;
      end
   end

   assign data_out = data_ff;
   assign flag_out = flag_ff;

endmodule

`default_nettype wire
